>>> hdl/gcm_pkg.sv
// gcm_pkg: constants, types and helper functions for the glyph colour matcher.
// Used by the interfaces, the match unit and the top level.
package gcm_pkg;

    localparam int TABLE_DEPTH   = 16384;
    localparam int MAX_ROW_WIDTH = 256;
    localparam int TBL_AW        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = TBL_AW + 1;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int ERR_DEPTH     = 3 * MAX_ROW_WIDTH;
    localparam int ERR_AW        = $clog2(ERR_DEPTH);
    localparam int EW            = 20;
    localparam int COST_W        = 42;
    localparam int CFG_IW        = 3;

    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam logic [CFG_IW-1:0] CFG_DITHER_MODE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SMOOTHNESS  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ROW_COUNT   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT = 3'd4;

    localparam logic [1:0] DM_NONE     = 2'd0;
    localparam logic [1:0] DM_FS       = 2'd1;
    localparam logic [1:0] DM_SIERRA   = 2'd2;
    localparam logic [1:0] DM_ATKINSON = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic signed [2:0] dx;
        logic [1:0]        dy;
        logic [2:0]        num;
    } tap_t;

    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        logic [47:0]       color;
        logic [31:0]       attr;
    } tbl_wr_t;

    typedef struct packed {
        logic                 start;
        logic signed [EW-1:0] pix_r;
        logic signed [EW-1:0] pix_g;
        logic signed [EW-1:0] pix_b;
        logic [CNT_W-1:0]     count;
        logic [15:0]          smooth;
    } match_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] color;
        logic [31:0] attr;
    } match_res_t;

    function automatic logic signed [EW-1:0] sat20(input logic signed [23:0] v);
        if (v > 24'sd524287)
            return 20'sd524287;
        else if (v < -24'sd524288)
            return -20'sd524288;
        else
            return v[EW-1:0];
    endfunction

    function automatic logic [3:0] tap_count(input logic [1:0] mode);
        case (mode)
            DM_FS:       return 4'd4;
            DM_SIERRA:   return 4'd10;
            DM_ATKINSON: return 4'd6;
            default:     return 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] tap_shift(input logic [1:0] mode);
        case (mode)
            DM_FS:       return 3'd4;
            DM_SIERRA:   return 3'd5;
            DM_ATKINSON: return 3'd3;
            default:     return 3'd0;
        endcase
    endfunction

    function automatic tap_t tap_get(input logic [1:0] mode, input logic [3:0] idx);
        tap_t t;
        t = '{3'sd0, 2'd0, 3'd0};
        case (mode)
            DM_FS: begin
                case (idx)
                    4'd0:    t = '{ 3'sd1, 2'd0, 3'd7};
                    4'd1:    t = '{-3'sd1, 2'd1, 3'd3};
                    4'd2:    t = '{ 3'sd0, 2'd1, 3'd5};
                    default: t = '{ 3'sd1, 2'd1, 3'd1};
                endcase
            end
            DM_SIERRA: begin
                case (idx)
                    4'd0:    t = '{ 3'sd1, 2'd0, 3'd5};
                    4'd1:    t = '{ 3'sd2, 2'd0, 3'd3};
                    4'd2:    t = '{-3'sd2, 2'd1, 3'd2};
                    4'd3:    t = '{-3'sd1, 2'd1, 3'd4};
                    4'd4:    t = '{ 3'sd0, 2'd1, 3'd5};
                    4'd5:    t = '{ 3'sd1, 2'd1, 3'd4};
                    4'd6:    t = '{ 3'sd2, 2'd1, 3'd2};
                    4'd7:    t = '{-3'sd1, 2'd2, 3'd2};
                    4'd8:    t = '{ 3'sd0, 2'd2, 3'd3};
                    default: t = '{ 3'sd1, 2'd2, 3'd2};
                endcase
            end
            DM_ATKINSON: begin
                case (idx)
                    4'd0:    t = '{ 3'sd1, 2'd0, 3'd1};
                    4'd1:    t = '{ 3'sd2, 2'd0, 3'd1};
                    4'd2:    t = '{-3'sd1, 2'd1, 3'd1};
                    4'd3:    t = '{ 3'sd0, 2'd1, 3'd1};
                    4'd4:    t = '{ 3'sd1, 2'd1, 3'd1};
                    default: t = '{ 3'sd0, 2'd2, 3'd1};
                endcase
            end
            default: t = '{3'sd0, 2'd0, 3'd0};
        endcase
        return t;
    endfunction

    // floor(e*num / 2^sh) added to old, saturated
    function automatic logic signed [EW-1:0] tap_add(input logic signed [EW-1:0] old,
                                                     input logic signed [EW-1:0] e,
                                                     input logic [2:0] num,
                                                     input logic [2:0] sh);
        logic signed [23:0] p;
        logic signed [23:0] q;
        p = $signed({{4{e[EW-1]}}, e}) * $signed({21'd0, num});
        q = p >>> sh;
        return sat20(q + $signed({{4{old[EW-1]}}, old}));
    endfunction

    // base-4 digit sums reduce v mod 3
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] r;
        s = 5'd0;
        for (int i = 0; i < 8; i++)
            s = s + 5'(v[2*i +: 2]);
        r = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (r >= 3'd6)
            r = r - 3'd6;
        else if (r >= 3'd3)
            r = r - 3'd3;
        return r[1:0];
    endfunction

    function automatic logic [ERR_AW-1:0] err_addr(input logic [1:0] slot,
                                                   input logic [COL_W-1:0] x);
        return ERR_AW'(slot) * ERR_AW'(MAX_ROW_WIDTH) + ERR_AW'(x);
    endfunction

endpackage

>>> hdl/gcm_ifs.sv
// gcm_ifs: valid/ready channel interfaces for pixel/load items, results and
// configuration writes. Depends on gcm_pkg.
interface gcm_in_if import gcm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [TBL_AW-1:0] entry_index;
    logic [15:0]       color_r;
    logic [15:0]       color_g;
    logic [15:0]       color_b;
    logic [15:0]       entry_contrast;
    logic [7:0]        entry_glyph;
    logic [3:0]        entry_fg;
    logic [3:0]        entry_bg;

    modport source (output valid, opcode, entry_index, color_r, color_g, color_b,
                    entry_contrast, entry_glyph, entry_fg, entry_bg, input ready);
    modport sink (input valid, opcode, entry_index, color_r, color_g, color_b,
                  entry_contrast, entry_glyph, entry_fg, entry_bg, output ready);
endinterface

interface gcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph_index;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       colors_changed;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, glyph_index, fg_color, bg_color, colors_changed,
                    row_end, frame_end, input ready);
    modport sink (input valid, glyph_index, fg_color, bg_color, colors_changed,
                  row_end, frame_end, output ready);
endinterface

interface gcm_cfg_if import gcm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [15:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/gcm_match.sv
// gcm_match: entry table memories and the pipelined least-cost scan.
// One entry read per cycle, three pipeline stages to the compare. Depends on gcm_pkg.
module gcm_match import gcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_wr_t    wr,
    input  match_req_t req,
    output match_res_t res
);

    logic [47:0] col_mem [TABLE_DEPTH];
    logic [31:0] attr_mem [TABLE_DEPTH];

    logic              scan_reg;
    logic [TBL_AW-1:0] addr_reg;
    logic [CNT_W-1:0]  left_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic              last1_reg, last2_reg, last3_reg;
    logic              first1_reg, first2_reg, first3_reg;
    logic              done_reg;

    logic [47:0]       rd_col_reg, col2_reg, col3_reg, best_col_reg;
    logic [31:0]       rd_attr_reg, attr2_reg, attr3_reg, best_attr_reg;
    logic [EW-1:0]     ad_r_reg, ad_g_reg, ad_b_reg;
    logic [35:0]       pr_r_reg, pr_g_reg, pr_b_reg;
    logic [31:0]       pc_reg;
    logic [COST_W-1:0] best_cost_reg;
    logic [COST_W-1:0] cost;
    logic              take;

    function automatic logic [EW-1:0] absdiff(input logic signed [EW-1:0] p,
                                              input logic [15:0] e);
        logic signed [EW:0] d;
        logic [EW:0]        nd;
        d  = $signed({p[EW-1], p}) - $signed({5'd0, e});
        nd = -d;
        return d[EW] ? nd[EW-1:0] : d[EW-1:0];
    endfunction

    always_ff @(posedge clk) begin
        if (wr.we) begin
            col_mem[wr.addr]  <= wr.color;
            attr_mem[wr.addr] <= wr.attr;
        end
        if (scan_reg) begin
            rd_col_reg  <= col_mem[addr_reg];
            rd_attr_reg <= attr_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scan_reg   <= 1'b0;
            addr_reg   <= '0;
            left_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            last1_reg  <= 1'b0;
            last2_reg  <= 1'b0;
            last3_reg  <= 1'b0;
            first1_reg <= 1'b0;
            first2_reg <= 1'b0;
            first3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else begin
            if (req.start) begin
                scan_reg <= 1'b1;
                addr_reg <= '0;
                left_reg <= req.count;
            end
            else if (scan_reg) begin
                addr_reg <= addr_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                    scan_reg <= 1'b0;
            end
            v1_reg     <= scan_reg;
            last1_reg  <= scan_reg && (left_reg == CNT_W'(1));
            first1_reg <= scan_reg && (addr_reg == '0);
            v2_reg     <= v1_reg;
            last2_reg  <= v1_reg && last1_reg;
            first2_reg <= v1_reg && first1_reg;
            v3_reg     <= v2_reg;
            last3_reg  <= v2_reg && last2_reg;
            first3_reg <= v2_reg && first2_reg;
            done_reg   <= v3_reg && last3_reg;
        end
    end

    assign cost = COST_W'(pr_r_reg) + COST_W'(pr_g_reg) + COST_W'(pr_b_reg)
                + {2'd0, pc_reg, 8'd0};
    // strictly smaller wins, so the first minimum holds
    assign take = v3_reg && (first3_reg || cost < best_cost_reg);

    always_ff @(posedge clk) begin
        ad_r_reg  <= absdiff(req.pix_r, rd_col_reg[15:0]);
        ad_g_reg  <= absdiff(req.pix_g, rd_col_reg[31:16]);
        ad_b_reg  <= absdiff(req.pix_b, rd_col_reg[47:32]);
        col2_reg  <= rd_col_reg;
        attr2_reg <= rd_attr_reg;
        pr_r_reg  <= 36'(ad_r_reg) * 36'(W_RED);
        pr_g_reg  <= 36'(ad_g_reg) * 36'(W_GREEN);
        pr_b_reg  <= 36'(ad_b_reg) * 36'(W_BLUE);
        pc_reg    <= 32'(attr2_reg[15:0]) * 32'(req.smooth);
        col3_reg  <= col2_reg;
        attr3_reg <= attr2_reg;
        if (take) begin
            best_cost_reg <= cost;
            best_col_reg  <= col3_reg;
            best_attr_reg <= attr3_reg;
        end
    end

    assign res.done  = done_reg;
    assign res.color = best_col_reg;
    assign res.attr  = best_attr_reg;

endmodule

>>> hdl/glyph_color_match_error_diffusion_unit.sv
// Flow: a load item is written to the entry table while idle; a pixel item's result
// waits on the one-entry-per-cycle scan over entry_count entries. The error line
// memory then takes a read and a write per tap inside the frame, and a clearing sweep
// of the row's slot at each row end, all of it at each frame end. One item at a time.
// Reset: control and configuration registers to defaults, then a clearing sweep of the
// error line memory during which no item is accepted; configuration writes always taken.
module glyph_color_match_error_diffusion_unit import gcm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    gcm_in_if.sink    pix_in,
    gcm_out_if.source res_out,
    gcm_cfg_if.sink   cfg
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_ERD   = 4'd3;
    localparam logic [3:0] S_PIX   = 4'd4;
    localparam logic [3:0] S_START = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TWR   = 4'd9;

    logic [3*EW-1:0] err_mem [ERR_DEPTH];
    logic [3*EW-1:0] em_rd_reg;
    logic            em_we, em_re;
    logic [ERR_AW-1:0] em_waddr, em_raddr;
    logic [3*EW-1:0] em_wdata;

    logic [1:0]  mode_reg;
    logic [15:0] smooth_reg;
    logic [8:0]  rwidth_reg;
    logic [15:0] rcount_reg;
    logic [14:0] ecount_reg;

    logic [3:0] state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next, x_reg, x_next;
    logic [15:0] row_reg, row_next, y_reg, y_next;
    logic [3:0]  last_fg_reg, last_fg_next, last_bg_reg, last_bg_next;
    logic        known_reg, known_next;
    logic [COL_W:0] width_reg, width_next;
    logic [15:0] rows_reg, rows_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]  slot_reg, slot_next;
    logic        rend_reg, rend_next, fend_reg, fend_next;
    logic [3:0]  tap_reg, tap_next;
    logic [ERR_AW-1:0] taddr_reg, taddr_next, clr_addr_reg, clr_addr_next;
    logic [ERR_AW-1:0] clr_last_reg, clr_last_next;
    logic [2:0]  tnum_reg, tnum_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] in_r_reg, in_r_next, in_g_reg, in_g_next, in_b_reg, in_b_next;
    logic signed [EW-1:0] pix_r_reg, pix_r_next, pix_g_reg, pix_g_next;
    logic signed [EW-1:0] pix_b_reg, pix_b_next;
    logic signed [EW-1:0] err_r_reg, err_r_next, err_g_reg, err_g_next;
    logic signed [EW-1:0] err_b_reg, err_b_next;
    logic [31:0] attr_reg, attr_next;
    logic [7:0]  o_glyph_reg, o_glyph_next;
    logic [3:0]  o_fg_reg, o_fg_next, o_bg_reg, o_bg_next;
    logic        o_chg_reg, o_chg_next, o_rend_reg, o_rend_next, o_fend_reg, o_fend_next;

    tbl_wr_t    tbl_wr;
    match_req_t mreq;
    match_res_t mres;

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = (state_reg == S_IDLE);

    assign tbl_wr.we    = pix_in.valid && pix_in.ready && (pix_in.opcode == OP_LOAD);
    assign tbl_wr.addr  = pix_in.entry_index;
    assign tbl_wr.color = {pix_in.color_b, pix_in.color_g, pix_in.color_r};
    assign tbl_wr.attr  = {pix_in.entry_bg, pix_in.entry_fg, pix_in.entry_glyph,
                           pix_in.entry_contrast};

    assign mreq.pix_r  = pix_r_reg;
    assign mreq.pix_g  = pix_g_reg;
    assign mreq.pix_b  = pix_b_reg;
    assign mreq.count  = count_reg;
    assign mreq.smooth = smooth_reg;
    assign mreq.start  = (state_reg == S_START);

    gcm_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .req   (mreq),
        .res   (mres)
    );

    always_ff @(posedge clk) begin
        if (em_we)
            err_mem[em_waddr] <= em_wdata;
        if (em_re)
            em_rd_reg <= err_mem[em_raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= DM_NONE;
            smooth_reg <= '0;
            rwidth_reg <= 9'd1;
            rcount_reg <= 16'd1;
            ecount_reg <= 15'd1;
        end
        else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_DITHER_MODE: mode_reg   <= cfg.data[1:0];
                CFG_SMOOTHNESS:  smooth_reg <= cfg.data;
                CFG_ROW_WIDTH:   rwidth_reg <= cfg.data[8:0];
                CFG_ROW_COUNT:   rcount_reg <= cfg.data;
                CFG_ENTRY_COUNT: ecount_reg <= cfg.data[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [COL_W:0]        w;
        logic [15:0]           r;
        logic [COL_W-1:0]      xa;
        logic [15:0]           ya;
        tap_t                  t;
        logic signed [COL_W+1:0] tx;
        logic [16:0]           ty;
        logic [2:0]            ts;
        logic                  tvalid;

        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        last_fg_next   = last_fg_reg;
        last_bg_next   = last_bg_reg;
        known_next     = known_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        width_next     = width_reg;
        rows_next      = rows_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        rend_next      = rend_reg;
        fend_next      = fend_reg;
        tap_next       = tap_reg;
        taddr_next     = taddr_reg;
        tnum_next      = tnum_reg;
        clr_addr_next  = clr_addr_reg;
        clr_last_next  = clr_last_reg;
        in_r_next      = in_r_reg;
        in_g_next      = in_g_reg;
        in_b_next      = in_b_reg;
        pix_r_next     = pix_r_reg;
        pix_g_next     = pix_g_reg;
        pix_b_next     = pix_b_reg;
        err_r_next     = err_r_reg;
        err_g_next     = err_g_reg;
        err_b_next     = err_b_reg;
        attr_next      = attr_reg;
        o_glyph_next   = o_glyph_reg;
        o_fg_next      = o_fg_reg;
        o_bg_next      = o_bg_reg;
        o_chg_next     = o_chg_reg;
        o_rend_next    = o_rend_reg;
        o_fend_next    = o_fend_reg;
        out_valid_next = out_valid_reg && !res_out.ready;
        em_we          = 1'b0;
        em_re          = 1'b0;
        em_waddr       = clr_addr_reg;
        em_raddr       = err_addr(slot_reg, x_reg);
        em_wdata       = '0;

        w      = '0;
        r      = '0;
        xa     = '0;
        ya     = '0;
        t      = tap_get(mode_reg, tap_reg);
        tx     = $signed({2'd0, x_reg}) + $signed({{(COL_W-1){t.dx[2]}}, t.dx});
        ty     = {1'b0, y_reg} + 17'(t.dy);
        ts     = 3'(slot_reg) + 3'(t.dy);
        if (ts >= 3'd3)
            ts = ts - 3'd3;
        tvalid = !tx[COL_W+1] && (tx < $signed({1'b0, width_reg}))
                 && (ty < {1'b0, rows_reg});

        unique case (state_reg)
            S_CLR: begin
                em_we    = 1'b1;
                em_waddr = clr_addr_reg;
                if (clr_addr_reg == clr_last_reg)
                    state_next = S_IDLE;
                else
                    clr_addr_next = clr_addr_reg + 1'b1;
            end
            S_IDLE: begin
                if (pix_in.valid && pix_in.opcode == OP_PIXEL) begin
                    w = (rwidth_reg == '0) ? (COL_W+1)'(1) : rwidth_reg;
                    if (w > (COL_W+1)'(MAX_ROW_WIDTH))
                        w = (COL_W+1)'(MAX_ROW_WIDTH);
                    r = (rcount_reg == '0) ? 16'd1 : rcount_reg;
                    xa = ({1'b0, col_reg} >= w) ? COL_W'(w - 1'b1) : col_reg;
                    ya = (row_reg >= r) ? r - 16'd1 : row_reg;
                    width_next = w;
                    rows_next  = r;
                    x_next     = xa;
                    y_next     = ya;
                    count_next = (ecount_reg == '0) ? CNT_W'(1) :
                                 (ecount_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) :
                                 ecount_reg;
                    rend_next  = ({1'b0, xa} + (COL_W+1)'(1)) >= w;
                    fend_next  = (({1'b0, xa} + (COL_W+1)'(1)) >= w)
                                 && (({1'b0, ya} + 17'd1) >= {1'b0, r});
                    in_r_next  = pix_in.color_r;
                    in_g_next  = pix_in.color_g;
                    in_b_next  = pix_in.color_b;
                    state_next = S_POS;
                end
            end
            S_POS: begin
                slot_next  = mod3_16(y_reg);
                state_next = S_ERD;
            end
            S_ERD: begin
                em_re      = 1'b1;
                em_raddr   = err_addr(slot_reg, x_reg);
                state_next = S_PIX;
            end
            S_PIX: begin
                pix_r_next = sat20($signed({8'd0, in_r_reg})
                             + $signed({{4{em_rd_reg[EW-1]}}, em_rd_reg[EW-1:0]}));
                pix_g_next = sat20($signed({8'd0, in_g_reg})
                             + $signed({{4{em_rd_reg[2*EW-1]}}, em_rd_reg[2*EW-1:EW]}));
                pix_b_next = sat20($signed({8'd0, in_b_reg})
                             + $signed({{4{em_rd_reg[3*EW-1]}}, em_rd_reg[3*EW-1:2*EW]}));
                state_next = S_START;
            end
            S_START: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (mres.done) begin
                    err_r_next = sat20($signed({{4{pix_r_reg[EW-1]}}, pix_r_reg})
                                 - $signed({8'd0, mres.color[15:0]}));
                    err_g_next = sat20($signed({{4{pix_g_reg[EW-1]}}, pix_g_reg})
                                 - $signed({8'd0, mres.color[31:16]}));
                    err_b_next = sat20($signed({{4{pix_b_reg[EW-1]}}, pix_b_reg})
                                 - $signed({8'd0, mres.color[47:32]}));
                    attr_next  = mres.attr;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!out_valid_reg || res_out.ready) begin
                    out_valid_next = 1'b1;
                    o_glyph_next   = attr_reg[23:16];
                    o_fg_next      = attr_reg[27:24];
                    o_bg_next      = attr_reg[31:28];
                    o_chg_next     = !known_reg || (attr_reg[27:24] != last_fg_reg)
                                     || (attr_reg[31:28] != last_bg_reg);
                    o_rend_next    = rend_reg;
                    o_fend_next    = fend_reg;
                    last_fg_next   = attr_reg[27:24];
                    last_bg_next   = attr_reg[31:28];
                    if (fend_reg) begin
                        col_next   = '0;
                        row_next   = '0;
                        known_next = 1'b0;
                    end
                    else if (rend_reg) begin
                        col_next   = '0;
                        row_next   = y_reg + 16'd1;
                        known_next = 1'b0;
                    end
                    else begin
                        col_next   = x_reg + 1'b1;
                        row_next   = y_reg;
                        known_next = 1'b1;
                    end
                    tap_next   = '0;
                    state_next = S_TRD;
                end
            end
            S_TRD: begin
                if (tap_reg >= tap_count(mode_reg)) begin
                    if (fend_reg) begin
                        clr_addr_next = '0;
                        clr_last_next = ERR_AW'(ERR_DEPTH - 1);
                        state_next    = S_CLR;
                    end
                    else if (rend_reg) begin
                        clr_addr_next = err_addr(slot_reg, '0);
                        clr_last_next = err_addr(slot_reg, COL_W'(MAX_ROW_WIDTH - 1));
                        state_next    = S_CLR;
                    end
                    else begin
                        state_next = S_IDLE;
                    end
                end
                else if (tvalid) begin
                    em_re      = 1'b1;
                    em_raddr   = err_addr(ts[1:0], tx[COL_W-1:0]);
                    taddr_next = err_addr(ts[1:0], tx[COL_W-1:0]);
                    tnum_next  = t.num;
                    state_next = S_TWR;
                end
                else begin
                    // drop taps off the frame
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_TWR: begin
                em_we      = 1'b1;
                em_waddr   = taddr_reg;
                em_wdata   = {tap_add(em_rd_reg[3*EW-1:2*EW], err_b_reg, tnum_reg,
                                      tap_shift(mode_reg)),
                              tap_add(em_rd_reg[2*EW-1:EW], err_g_reg, tnum_reg,
                                      tap_shift(mode_reg)),
                              tap_add(em_rd_reg[EW-1:0], err_r_reg, tnum_reg,
                                      tap_shift(mode_reg))};
                tap_next   = tap_reg + 1'b1;
                state_next = S_TRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            clr_last_reg  <= ERR_AW'(ERR_DEPTH - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            last_fg_reg   <= '0;
            last_bg_reg   <= '0;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            tap_reg       <= '0;
        end
        else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_last_reg  <= clr_last_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            last_fg_reg   <= last_fg_next;
            last_bg_reg   <= last_bg_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
            tap_reg       <= tap_next;
        end
    end

    always_ff @(posedge clk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        width_reg   <= width_next;
        rows_reg    <= rows_next;
        count_reg   <= count_next;
        slot_reg    <= slot_next;
        rend_reg    <= rend_next;
        fend_reg    <= fend_next;
        taddr_reg   <= taddr_next;
        tnum_reg    <= tnum_next;
        in_r_reg    <= in_r_next;
        in_g_reg    <= in_g_next;
        in_b_reg    <= in_b_next;
        pix_r_reg   <= pix_r_next;
        pix_g_reg   <= pix_g_next;
        pix_b_reg   <= pix_b_next;
        err_r_reg   <= err_r_next;
        err_g_reg   <= err_g_next;
        err_b_reg   <= err_b_next;
        attr_reg    <= attr_next;
        o_glyph_reg <= o_glyph_next;
        o_fg_reg    <= o_fg_next;
        o_bg_reg    <= o_bg_next;
        o_chg_reg   <= o_chg_next;
        o_rend_reg  <= o_rend_next;
        o_fend_reg  <= o_fend_next;
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.glyph_index    = o_glyph_reg;
    assign res_out.fg_color       = o_fg_reg;
    assign res_out.bg_color       = o_bg_reg;
    assign res_out.colors_changed = o_chg_reg;
    assign res_out.row_end        = o_rend_reg;
    assign res_out.frame_end      = o_fend_reg;

endmodule

>>> hdl/gcm_checker.sv
// gcm_checker: port-level assertions for the glyph colour matcher, bound to
// the top level. Depends on the top level's port names only.
module gcm_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_opcode,
    input logic out_valid,
    input logic out_ready,
    input logic out_row_end,
    input logic out_frame_end
);

    // a frame always ends on a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_frame_end || out_row_end))
        else $error("frame_end without row_end");

    // a pixel item keeps the block busy
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_opcode) |=> !in_ready)
        else $error("ready after pixel item");

    // a new result only appears while the block is busy
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result emitted while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result item dropped");

endmodule

bind glyph_color_match_error_diffusion_unit gcm_checker u_gcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix_in.valid),
    .in_ready      (pix_in.ready),
    .in_opcode     (pix_in.opcode),
    .out_valid     (res_out.valid),
    .out_ready     (res_out.ready),
    .out_row_end   (res_out.row_end),
    .out_frame_end (res_out.frame_end)
);
